FILE: design/lxm_pkg.sv
`timescale 1ns / 1ps

package lxm_pkg;

    localparam int          WordW      = 64;
    localparam int          HalfW      = 32;
    localparam int          StepW      = 4;
    localparam int          CfgIdxW    = 3;
    localparam logic [63:0] LEA_MUL    = 64'hdaba0b6eb09322e3;
    localparam logic [63:0] DEFAULT_MUL = 64'hd1342543de82ef95;
    localparam int          XBG_SHIFT  = 17;
    localparam int          XBG_ROT    = 45;

    localparam logic [CfgIdxW-1:0] REG_ADDEND = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MULT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SEED_L = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SEED_0 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SEED_1 = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SEED_2 = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SEED_3 = 3'd6;

    localparam logic [1:0] Z_NONE = 2'd0;
    localparam logic [1:0] Z_SUM  = 2'd1;
    localparam logic [1:0] Z_ACC  = 2'd2;

    localparam logic [1:0] MA_ZL = 2'd0;
    localparam logic [1:0] MA_ZH = 2'd1;
    localparam logic [1:0] MA_SL = 2'd2;
    localparam logic [1:0] MA_SH = 2'd3;

    localparam logic [1:0] MB_LL = 2'd0;
    localparam logic [1:0] MB_LH = 2'd1;
    localparam logic [1:0] MB_ML = 2'd2;
    localparam logic [1:0] MB_MH = 2'd3;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADDHI = 2'd2;

    localparam logic JMP_NEXT = 1'b0;
    localparam logic JMP_EMIT = 1'b1;

    localparam logic [StepW-1:0] LAST_STEP = 4'd13;

    typedef struct packed {
        logic       start;
        logic [1:0] z_op;
        logic       xbg_step;
        logic [1:0] mul_a;
        logic [1:0] mul_b;
        logic [1:0] acc_op;
        logic       lcg_upd;
        logic       jmp;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        start: 1'b0, z_op: Z_NONE, xbg_step: 1'b0, mul_a: MA_ZL, mul_b: MB_LL,
        acc_op: ACC_NONE, lcg_upd: 1'b0, jmp: JMP_NEXT
    };

    function automatic ctrl_t ctrl_rom(input logic [StepW-1:0] step);
        ctrl_t c;
        c = CTRL_NOP;
        case (step)
            4'd0:
            begin
                c.z_op     = Z_SUM;
                c.xbg_step = 1'b1;
            end
            4'd1, 4'd5:
            begin
                c.mul_a = MA_ZL;
                c.mul_b = MB_LL;
            end
            4'd2, 4'd6:
            begin
                c.acc_op = ACC_LOAD;
                c.mul_a  = MA_ZH;
                c.mul_b  = MB_LL;
            end
            4'd3, 4'd7:
            begin
                c.acc_op = ACC_ADDHI;
                c.mul_a  = MA_ZL;
                c.mul_b  = MB_LH;
            end
            4'd4, 4'd8:
            begin
                c.acc_op = ACC_ADDHI;
                c.z_op   = Z_ACC;
            end
            4'd9:
            begin
                c.mul_a = MA_SL;
                c.mul_b = MB_ML;
            end
            4'd10:
            begin
                c.acc_op = ACC_LOAD;
                c.mul_a  = MA_SH;
                c.mul_b  = MB_ML;
            end
            4'd11:
            begin
                c.acc_op = ACC_ADDHI;
                c.mul_a  = MA_SL;
                c.mul_b  = MB_MH;
            end
            4'd12:
            begin
                c.acc_op = ACC_ADDHI;
            end
            LAST_STEP:
            begin
                c.lcg_upd = 1'b1;
                c.jmp     = JMP_EMIT;
            end
            default:
            begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

    function automatic logic [63:0] fold(input logic [63:0] z);
        return z ^ {32'd0, z[63:32]};
    endfunction

endpackage

FILE: design/lxm_seq.sv
`timescale 1ns / 1ps

module lxm_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_free,
    output logic               in_stall,
    output lxm_pkg::ctrl_t     ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [lxm_pkg::StepW-1:0]  step_reg;
    logic [lxm_pkg::StepW-1:0]  step_next;
    lxm_pkg::ctrl_t             word;

    assign word     = lxm_pkg::ctrl_rom(step_reg);
    assign in_stall = (state_reg == ST_RUN);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl       = lxm_pkg::CTRL_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.start = in_valid;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                ctrl = word;
                if (word.jmp == lxm_pkg::JMP_EMIT)
                begin
                    // hold on this step until the output slot frees
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: design/lxm_dp.sv
`timescale 1ns / 1ps

module lxm_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lxm_pkg::ctrl_t                ctrl,
    input  logic                          reload,
    input  logic                          cfg_write,
    input  logic [lxm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [lxm_pkg::WordW-1:0]     cfg_data,
    input  logic                          out_stall,
    output logic                          out_free,
    output logic                          out_valid,
    output logic [lxm_pkg::WordW-1:0]     random_value
);

    logic [63:0] addend_reg, mult_reg, seed_l_reg;
    logic [63:0] seed0_reg, seed1_reg, seed2_reg, seed3_reg;
    logic [63:0] lcg_reg, w0_reg, w1_reg, w2_reg, w3_reg;
    logic [63:0] z_reg, z_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] out_reg;
    logic        out_valid_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] w3_x;
    logic        emit;

    assign out_free     = !out_valid_reg || !out_stall;
    assign emit         = (ctrl.jmp == lxm_pkg::JMP_EMIT) && out_free;
    assign out_valid    = out_valid_reg;
    assign random_value = out_reg;

    always_comb
    begin
        case (ctrl.mul_a)
            lxm_pkg::MA_ZL: mul_a = z_reg[31:0];
            lxm_pkg::MA_ZH: mul_a = z_reg[63:32];
            lxm_pkg::MA_SL: mul_a = lcg_reg[31:0];
            lxm_pkg::MA_SH: mul_a = lcg_reg[63:32];
            default:        mul_a = z_reg[31:0];
        endcase
        case (ctrl.mul_b)
            lxm_pkg::MB_LL: mul_b = lxm_pkg::LEA_MUL[31:0];
            lxm_pkg::MB_LH: mul_b = lxm_pkg::LEA_MUL[63:32];
            lxm_pkg::MB_ML: mul_b = mult_reg[31:0];
            lxm_pkg::MB_MH: mul_b = mult_reg[63:32];
            default:        mul_b = lxm_pkg::LEA_MUL[31:0];
        endcase
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        case (ctrl.acc_op)
            lxm_pkg::ACC_LOAD:  acc_next = prod_reg;
            lxm_pkg::ACC_ADDHI: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            default:            acc_next = acc_reg;
        endcase
        case (ctrl.z_op)
            lxm_pkg::Z_SUM: z_next = lxm_pkg::fold(lcg_reg + w0_reg);
            lxm_pkg::Z_ACC: z_next = lxm_pkg::fold(acc_next);
            default:        z_next = z_reg;
        endcase
    end

    assign w3_x = w3_reg ^ w1_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        if (emit)
        begin
            out_reg <= z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addend_reg <= 64'd1;
            mult_reg   <= lxm_pkg::DEFAULT_MUL;
            seed_l_reg <= 64'd0;
            seed0_reg  <= 64'd1;
            seed1_reg  <= 64'd0;
            seed2_reg  <= 64'd0;
            seed3_reg  <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lxm_pkg::REG_ADDEND: addend_reg <= cfg_data;
                lxm_pkg::REG_MULT:   mult_reg   <= cfg_data;
                lxm_pkg::REG_SEED_L: seed_l_reg <= cfg_data;
                lxm_pkg::REG_SEED_0: seed0_reg  <= cfg_data;
                lxm_pkg::REG_SEED_1: seed1_reg  <= cfg_data;
                lxm_pkg::REG_SEED_2: seed2_reg  <= cfg_data;
                lxm_pkg::REG_SEED_3: seed3_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg <= 64'd0;
            w0_reg  <= 64'd1;
            w1_reg  <= 64'd0;
            w2_reg  <= 64'd0;
            w3_reg  <= 64'd0;
        end
        else if (ctrl.start && reload)
        begin
            lcg_reg <= seed_l_reg;
            w0_reg  <= seed0_reg;
            w1_reg  <= seed1_reg;
            w2_reg  <= seed2_reg;
            w3_reg  <= seed3_reg;
        end
        else
        begin
            if (ctrl.lcg_upd)
            begin
                lcg_reg <= acc_reg + (addend_reg | 64'd1);
            end
            if (ctrl.xbg_step)
            begin
                w0_reg <= w0_reg ^ w3_x;
                w1_reg <= w1_reg ^ w2_reg ^ w0_reg;
                w2_reg <= w2_reg ^ w0_reg ^ (w1_reg << lxm_pkg::XBG_SHIFT);
                w3_reg <= {w3_x[63-lxm_pkg::XBG_ROT:0], w3_x[63:64-lxm_pkg::XBG_ROT]};
            end
        end
    end

endmodule

FILE: design/lxm_l64x256_mix_prng.sv
`timescale 1ns / 1ps

// LXM L64X256 mix generator: one 64-bit random value per input beat.
// Input channel: in_valid / in_stall carry the reload bit. With reload high the
// seed registers are copied into the generator state before the draw.
// Output channel: out_valid / out_stall carry random_value.
// Configuration: cfg_write with cfg_index and cfg_data writes one of seven
// 64-bit registers (addend, multiplier, LCG seed, four xoshiro seed words);
// indexes above six are ignored. Write only while the block is idle.
// Operation: a beat is taken in the idle cycle, then a 14-step microprogram runs
// on one shared 32x32 multiplier: three 64-bit products (two mixer rounds and
// the LCG step), each built from three partial products. The input stalls while
// the program runs, so no new beat is taken until it is done. If the receiver
// stalls, the previous result stays in the output register and the program
// holds on its final step until that slot frees, then returns to idle.
// Reset: state returns to LCG 0 and xoshiro words {1,0,0,0}, registers to their
// defaults, output empty.

module lxm_l64x256_mix_prng
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          reload,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lxm_pkg::WordW-1:0]     random_value,
    input  logic                          cfg_write,
    input  logic [lxm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [lxm_pkg::WordW-1:0]     cfg_data
);

    lxm_pkg::ctrl_t ctrl;
    logic           out_free;

    lxm_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    lxm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .reload       (reload),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .random_value (random_value)
    );

endmodule

FILE: tb/lxm_prng_checker.sv
`timescale 1ns / 1ps

module lxm_prng_checker
    import lxm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               reload,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [WordW-1:0]   random_value,
    input  logic               cfg_write,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [WordW-1:0]   cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int NumRegs     = 7;

    logic [WordW-1:0] reg_file [NumRegs];
    logic [WordW-1:0] lcg_word;
    logic [WordW-1:0] xbg [4];
    logic [WordW-1:0] expected_values [$];
    int               errs = 0;

    task automatic report_mismatch(input string msg);
        errs++;
        $display("[%0t] random_value mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        logic [WordW-1:0] z;
        logic [WordW-1:0] t;
        logic [WordW-1:0] want;
        if (!rst_n)
        begin
            reg_file[REG_ADDEND] = 64'd1;
            reg_file[REG_MULT]   = DEFAULT_MUL;
            reg_file[REG_SEED_L] = 64'd0;
            reg_file[REG_SEED_0] = 64'd1;
            reg_file[REG_SEED_1] = 64'd0;
            reg_file[REG_SEED_2] = 64'd0;
            reg_file[REG_SEED_3] = 64'd0;
            lcg_word = 64'd0;
            xbg[0] = 64'd1;
            xbg[1] = 64'd0;
            xbg[2] = 64'd0;
            xbg[3] = 64'd0;
            expected_values.delete();
            fail_count <= errs;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write && cfg_index <= REG_SEED_3)
                reg_file[cfg_index] = cfg_data;

            if (in_valid && !in_stall)
            begin
                if (reload)
                begin
                    lcg_word = reg_file[REG_SEED_L];
                    xbg[0] = reg_file[REG_SEED_0];
                    xbg[1] = reg_file[REG_SEED_1];
                    xbg[2] = reg_file[REG_SEED_2];
                    xbg[3] = reg_file[REG_SEED_3];
                end

                // mix the sum of LCG and first xoshiro word
                z = lcg_word + xbg[0];
                z = (z ^ (z >> HalfW)) * LEA_MUL;
                z = (z ^ (z >> HalfW)) * LEA_MUL;
                expected_values.push_back(z ^ (z >> HalfW));

                // advance both generators
                lcg_word = reg_file[REG_MULT] * lcg_word + (reg_file[REG_ADDEND] | 64'd1);
                t = xbg[1] << XBG_SHIFT;
                xbg[2] = xbg[2] ^ xbg[0];
                xbg[3] = xbg[3] ^ xbg[1];
                xbg[1] = xbg[1] ^ xbg[2];
                xbg[0] = xbg[0] ^ xbg[3];
                xbg[2] = xbg[2] ^ t;
                xbg[3] = (xbg[3] << XBG_ROT) | (xbg[3] >> (WordW - XBG_ROT));
            end

            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch($sformatf("beat %h with no draw outstanding",
                                              random_value));
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (random_value !== want)
                        report_mismatch($sformatf("got %h, want %h", random_value, want));
                end
            end

            fail_count <= errs;
            pending    <= expected_values.size();
        end
    end

endmodule

FILE: tb/tb_lxm_l64x256_mix_prng.sv
`timescale 1ns / 1ps

module tb_lxm_l64x256_mix_prng;
    import lxm_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
    localparam logic [WordW-1:0]   AllOnes    = {WordW{1'b1}};
    localparam int HoldCycles   = 200;
    localparam int RandomPhases = 12;
    localparam int PhaseDraws   = 155;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic               reload     = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [WordW-1:0]   random_value;
    logic               cfg_write  = 1'b0;
    logic [CfgIdxW-1:0] cfg_index  = '0;
    logic [WordW-1:0]   cfg_data   = '0;
    int                 fail_count;
    int                 pending;

    bit rx_random_stalls = 1'b0;
    bit rx_hold_req      = 1'b0;
    bit tx_random_gaps   = 1'b0;
    int draws_sent       = 0;
    int reloads_sent     = 0;
    int reg_writes       = 0;
    int settings_used    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lxm_l64x256_mix_prng u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .reload       (reload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lxm_prng_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .reload       (reload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    function automatic logic [WordW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return AllOnes;
            2:       return {{(WordW-1){1'b0}}, 1'b1} << $urandom_range(0, WordW - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_draw(input logic rl);
        int gap;
        in_valid <= 1'b1;
        reload   <= rl;
        do @(posedge clk); while (in_stall);
        draws_sent++;
        if (rl)
            reloads_sent++;
        if (tx_random_gaps)
        begin
            gap = $urandom_range(0, 99);
            if (gap < 45)
                gap = 0;
            else if (gap < 95)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(15, 60);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write all seven registers, then poke the unused index with junk
    task automatic load_setting(input logic [WordW-1:0] vals [7]);
        logic [CfgIdxW-1:0] idx;
        for (idx = REG_ADDEND; idx <= REG_SEED_3; idx++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            reg_writes++;
        end
        cfg_index <= REG_UNUSED;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        reg_writes++;
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : receiver
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_random_stalls)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (len - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        logic [WordW-1:0] vals [7];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, then reload from the default seeds
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b0);
        wait_drained();

        // even addend of zero, everything else all ones
        vals = '{64'd0, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes};
        load_setting(vals);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        wait_drained();

        // zero multiplier and an all-zero xoshiro seed: output tracks the LCG alone
        vals = '{AllOnes, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
        load_setting(vals);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b0);
        wait_drained();

        vals = '{64'd2, 64'd1, 64'h8000_0000_0000_0000, 64'd1,
                 64'h8000_0000_0000_0000, 64'd1 << XBG_SHIFT, 64'd1 << XBG_ROT};
        load_setting(vals);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b0);
        wait_drained();

        // receiver holds off while the sender keeps offering beats
        vals = '{rand_word(), DEFAULT_MUL, rand_word(), {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
        load_setting(vals);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_draw(i == 0);
        wait_drained();

        for (int p = 0; p < RandomPhases; p++)
        begin
            foreach (vals[r])
                vals[r] = rand_word();
            if (p % 3 == 0)
                vals[REG_MULT] = DEFAULT_MUL;
            load_setting(vals);
            rx_random_stalls = (p % 4 != 1);
            tx_random_gaps   = (p % 4 != 1);
            for (int i = 0; i < PhaseDraws; i++)
                send_draw(i == 0 || $urandom_range(0, 9) == 0);
            wait_drained();
        end

        repeat (20) @(posedge clk);

        $display("Covered %0d draws (%0d with reload) over %0d register settings, %0d writes",
                 draws_sent, reloads_sent, settings_used, reg_writes);
        $display("including a %0d-cycle receiver hold-off and drains between settings",
                 HoldCycles);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("** lxm_l64x256_mix_prng: PASSED **");
        else
            $display("** lxm_l64x256_mix_prng: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Timeout: %0d draws sent, %0d results outstanding", draws_sent, pending);
        $display("** lxm_l64x256_mix_prng: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
design/lxm_pkg.sv
design/lxm_seq.sv
design/lxm_dp.sv
design/lxm_l64x256_mix_prng.sv
tb/lxm_prng_checker.sv
tb/tb_lxm_l64x256_mix_prng.sv
